FILE: design/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types, constants and codes for the per-layer range tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

    // Table depth and count width.
    localparam int MAX_LAYERS = 16;
    localparam int COUNT_BITS = 24;

    localparam int ADDR_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int USED_W = $clog2(MAX_LAYERS + 1);

    // Fixed field widths of the result word.
    localparam int LIDX_W    = 5;
    localparam int SAMPLES_W = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Bounding box corner start values, +/-10000.0 in Q16.16.
    localparam logic signed [31:0] BOX_LOW_RESET  = 32'sd655360000;
    localparam logic signed [31:0] BOX_HIGH_RESET = -32'sd655360000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] density;
    } t_sample;

    typedef struct packed {
        logic [LIDX_W-1:0]    layer_index;
        logic                 new_layer;
        logic [SAMPLES_W-1:0] layer_samples;
        logic signed [31:0]   layer_den_min;
        logic signed [31:0]   layer_den_max;
        logic signed [31:0]   box_min_x;
        logic signed [31:0]   box_max_x;
        logic signed [31:0]   box_min_y;
        logic signed [31:0]   box_max_y;
        logic signed [31:0]   box_min_z;
        logic signed [31:0]   box_max_z;
        logic                 table_full;
    } t_result;

    // Outcome of the key search.
    typedef struct packed {
        logic              hit;
        logic              full;
        logic [ADDR_W-1:0] idx;
    } t_lookup;

    // One layer entry held in the layer memory.
    typedef struct packed {
        logic signed [31:0]    den_min;
        logic signed [31:0]    den_max;
        logic [COUNT_BITS-1:0] count;
    } t_layer_rec;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_z;
    } t_box;

endpackage

FILE: design/prt_key_match.sv
// ----------------------------------------------------------------------------
// prt_key_match
// Layer key registers with a parallel exact-match search and allocation.
// ----------------------------------------------------------------------------
module prt_key_match
    import prt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_key,
    input  logic               i_alloc,
    input  logic [ADDR_W-1:0]  i_alloc_idx,
    output t_lookup            o_lookup
);

    logic signed [31:0] r_key [MAX_LAYERS];
    logic [USED_W-1:0]  r_used;
    logic               hit;
    logic [ADDR_W-1:0]  hit_idx;

    // Key store: no reset, entries at or above the fill count are never compared.
    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_key[i_alloc_idx] <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_alloc) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    // Lowest matching entry wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
            if ((USED_W'(i) < r_used) && (r_key[i] == i_key)) begin
                hit     = 1'b1;
                hit_idx = ADDR_W'(i);
            end
        end
    end

    always_comb begin
        o_lookup.hit  = hit;
        o_lookup.full = !hit && (r_used == USED_W'(MAX_LAYERS));
        o_lookup.idx  = hit ? hit_idx : r_used[ADDR_W-1:0];
    end

endmodule

FILE: design/prt_layer_store.sv
// ----------------------------------------------------------------------------
// prt_layer_store
// Layer memory (min, max, count) with registered read and the update logic.
// ----------------------------------------------------------------------------
module prt_layer_store
    import prt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    input  logic               i_wr_en,
    input  t_lookup            i_lookup,
    input  logic signed [31:0] i_den,
    output t_layer_rec         o_rec
);

    t_layer_rec r_mem [MAX_LAYERS];
    t_layer_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_lookup.idx] <= o_rec;
        end
    end

    // Merge on a hit, seed a fresh entry on a miss.
    always_comb begin
        if (i_lookup.hit) begin
            o_rec.den_min = (i_den < r_rdata.den_min) ? i_den : r_rdata.den_min;
            o_rec.den_max = (i_den > r_rdata.den_max) ? i_den : r_rdata.den_max;
            o_rec.count   = (r_rdata.count != COUNT_MAX) ?
                            r_rdata.count + COUNT_BITS'(1) : r_rdata.count;
        end else begin
            o_rec.den_min = i_den;
            o_rec.den_max = i_den;
            o_rec.count   = COUNT_BITS'(1);
        end
    end

endmodule

FILE: design/prt_box.sv
// ----------------------------------------------------------------------------
// prt_box
// Bounding box corner registers.
// ----------------------------------------------------------------------------
module prt_box
    import prt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_sample i_sample,
    output t_box    o_box
);

    t_box r_box;
    t_box n_box;

    always_comb begin
        n_box       = r_box;
        n_box.min_x = (i_sample.pos_x < r_box.min_x) ? i_sample.pos_x : r_box.min_x;
        n_box.max_x = (i_sample.pos_x > r_box.max_x) ? i_sample.pos_x : r_box.max_x;
        n_box.min_y = (i_sample.pos_y < r_box.min_y) ? i_sample.pos_y : r_box.min_y;
        n_box.max_y = (i_sample.pos_y > r_box.max_y) ? i_sample.pos_y : r_box.max_y;
        n_box.min_z = (i_sample.pos_z < r_box.min_z) ? i_sample.pos_z : r_box.min_z;
        n_box.max_z = (i_sample.pos_z > r_box.max_z) ? i_sample.pos_z : r_box.max_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.min_x <= BOX_LOW_RESET;
            r_box.max_x <= BOX_HIGH_RESET;
            r_box.min_y <= BOX_LOW_RESET;
            r_box.max_y <= BOX_HIGH_RESET;
            r_box.min_z <= BOX_LOW_RESET;
            r_box.max_z <= BOX_HIGH_RESET;
        end else if (i_en) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

FILE: design/per_layer_range_tracker.sv
// ----------------------------------------------------------------------------
// per_layer_range_tracker
// Groups samples by z and tracks per-layer density range, count and box.
// ----------------------------------------------------------------------------
// Each accepted sample is handled in order: the word is latched, the key
// registers are searched and the layer memory read, then the entry is merged
// and written back; the registered result word shows on o_result with o_valid
// for exactly one cycle right after. busy is high in the read and update
// states, so no new word is taken while one is in work; a new word may be
// started in the cycle its predecessor's result is shown. The receiver
// cannot stall, so capture o_result whenever o_valid is high. A sample whose
// z is new once all layers are in use is reported with table_full set,
// layer_index equal to the layer count and zeroed layer fields; the bounding
// box still follows every sample.
// ----------------------------------------------------------------------------
module per_layer_range_tracker
    import prt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_sample i_sample,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_state     r_state;
    t_state     n_state;
    t_sample    r_sample;
    t_lookup    r_lookup;
    t_lookup    lookup;
    t_layer_rec rec;
    t_box       box;
    t_result    r_result;
    t_result    n_result;
    logic       r_valid;

    logic accept;
    logic rd_en;
    logic wr_en;
    logic alloc;
    logic box_en;
    logic res_load;

    assign accept = start && !busy;

    // Next state: idle -> read -> update -> idle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_READ;
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        busy     = 1'b0;
        rd_en    = 1'b0;
        box_en   = 1'b0;
        res_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_READ: begin
                busy   = 1'b1;
                rd_en  = 1'b1;
                box_en = 1'b1;
            end
            S_UPDATE: begin
                busy     = 1'b1;
                res_load = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Write back on a hit or a fresh entry; drop when the table is full.
    assign wr_en = res_load && !r_lookup.full;
    assign alloc = res_load && !r_lookup.hit && !r_lookup.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= res_load;
        end
    end

    // Hold the sample and the search outcome for the update cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (rd_en) begin
            r_lookup <= lookup;
        end
    end

    prt_key_match u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_sample.pos_z),
        .i_alloc     (alloc),
        .i_alloc_idx (r_lookup.idx),
        .o_lookup    (lookup)
    );

    prt_layer_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (lookup.idx),
        .i_wr_en   (wr_en),
        .i_lookup  (r_lookup),
        .i_den     (r_sample.density),
        .o_rec     (rec)
    );

    prt_box u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (box_en),
        .i_sample (r_sample),
        .o_box    (box)
    );

    // Assemble the result word.
    always_comb begin
        n_result.box_min_x  = box.min_x;
        n_result.box_max_x  = box.max_x;
        n_result.box_min_y  = box.min_y;
        n_result.box_max_y  = box.max_y;
        n_result.box_min_z  = box.min_z;
        n_result.box_max_z  = box.max_z;
        n_result.table_full = r_lookup.full;
        if (r_lookup.full) begin
            n_result.layer_index   = LIDX_W'(MAX_LAYERS);
            n_result.new_layer     = 1'b0;
            n_result.layer_samples = '0;
            n_result.layer_den_min = '0;
            n_result.layer_den_max = '0;
        end else begin
            n_result.layer_index   = LIDX_W'(r_lookup.idx);
            n_result.new_layer     = !r_lookup.hit;
            n_result.layer_samples = SAMPLES_W'(rec.count);
            n_result.layer_den_min = rec.den_min;
            n_result.layer_den_max = rec.den_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/prt_checker.sv
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks for the per-layer range tracker.
// ----------------------------------------------------------------------------
module prt_checker
    import prt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_valid,
    input t_result o_result
);

    // A started word keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after start");

    // Results never come in adjacent cycles.
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // A dropped sample reports the full code and no layer data.
    a_full_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.table_full) |->
        (o_result.layer_index == LIDX_W'(MAX_LAYERS)) && !o_result.new_layer &&
        (o_result.layer_samples == '0))
        else $error("bad table-full result");

    // A fresh layer holds one sample with a single density.
    a_new_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.new_layer) |->
        (o_result.layer_samples == SAMPLES_W'(1)) &&
        (o_result.layer_den_min == o_result.layer_den_max) && !o_result.table_full)
        else $error("bad new-layer result");

    // Range stays ordered for any recorded sample.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.table_full) |->
        (o_result.layer_den_min <= o_result.layer_den_max))
        else $error("layer min above max");

endmodule

bind per_layer_range_tracker prt_checker u_prt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-layer range tracker.
// ----------------------------------------------------------------------------
// Drive sample words through the start/busy handshake and mirror the layer
// table and bounding box in a local scoreboard. Every accepted word queues
// one predicted result word; every o_valid pulse is checked field by field
// against the oldest prediction. A directed opener fills the layer table,
// hits the density and coordinate extremes and overflows the table. Random
// traffic then mostly revisits known layers, with some new and near-miss
// keys, under three sender idling profiles.
// ----------------------------------------------------------------------------
module tb;
    import prt_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror the table and box, queue expected words, compare.
    // ------------------------------------------------------------------------
    class range_checker;
        logic signed [31:0]    key_tab [MAX_LAYERS];
        logic signed [31:0]    min_tab [MAX_LAYERS];
        logic signed [31:0]    max_tab [MAX_LAYERS];
        logic [COUNT_BITS-1:0] cnt_tab [MAX_LAYERS];
        int                    used;
        logic signed [31:0]    box_lo [3];
        logic signed [31:0]    box_hi [3];
        t_result               due_results [$];
        int                    errors;

        function new();
            used   = 0;
            errors = 0;
            for (int a = 0; a < 3; a++) begin
                box_lo[a] = BOX_LOW_RESET;
                box_hi[a] = BOX_HIGH_RESET;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Fold one accepted sample into the mirror and queue its result word.
        function void log_sample(input t_sample s);
            logic signed [31:0] pos [3];
            logic signed [31:0] den;
            t_result            r;
            int                 hit;
            pos[0] = s.pos_x;
            pos[1] = s.pos_y;
            pos[2] = s.pos_z;
            den    = s.density;
            r      = '0;
            hit    = -1;

            // The box follows every sample, recorded in a layer or not.
            for (int a = 0; a < 3; a++) begin
                if (pos[a] < box_lo[a]) box_lo[a] = pos[a];
                if (pos[a] > box_hi[a]) box_hi[a] = pos[a];
            end

            for (int k = 0; k < used; k++) begin
                if (hit < 0 && key_tab[k] == pos[2]) hit = k;
            end

            if (hit >= 0) begin
                if (den < min_tab[hit]) min_tab[hit] = den;
                if (den > max_tab[hit]) max_tab[hit] = den;
                if (cnt_tab[hit] != COUNT_MAX) cnt_tab[hit] = cnt_tab[hit] + 1'b1;
            end else if (used < MAX_LAYERS) begin
                hit          = used;
                used         = used + 1;
                key_tab[hit] = pos[2];
                min_tab[hit] = den;
                max_tab[hit] = den;
                cnt_tab[hit] = COUNT_BITS'(1);
                r.new_layer  = 1'b1;
            end

            if (hit < 0) begin
                r.layer_index = LIDX_W'(MAX_LAYERS);
                r.table_full  = 1'b1;
            end else begin
                r.layer_index   = LIDX_W'(hit);
                r.layer_samples = cnt_tab[hit][SAMPLES_W-1:0];
                r.layer_den_min = min_tab[hit];
                r.layer_den_max = max_tab[hit];
            end
            r.box_min_x = box_lo[0];
            r.box_max_x = box_hi[0];
            r.box_min_y = box_lo[1];
            r.box_max_y = box_hi[1];
            r.box_min_z = box_lo[2];
            r.box_max_z = box_hi[2];
            due_results = {due_results, r};
        endfunction

        task compare_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(input t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report("result word with no sample outstanding");
            end else begin
                want = due_results.pop_front();
                compare_field("layer_index", 32'(got.layer_index), 32'(want.layer_index));
                compare_field("new_layer", 32'(got.new_layer), 32'(want.new_layer));
                compare_field("layer_samples", 32'(got.layer_samples),
                              32'(want.layer_samples));
                compare_field("layer_den_min", got.layer_den_min, want.layer_den_min);
                compare_field("layer_den_max", got.layer_den_max, want.layer_den_max);
                compare_field("box_min_x", got.box_min_x, want.box_min_x);
                compare_field("box_max_x", got.box_max_x, want.box_max_x);
                compare_field("box_min_y", got.box_min_y, want.box_min_y);
                compare_field("box_max_y", got.box_max_y, want.box_max_y);
                compare_field("box_min_z", got.box_min_z, want.box_min_z);
                compare_field("box_max_z", got.box_max_z, want.box_max_z);
                compare_field("table_full", 32'(got.table_full), 32'(want.table_full));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_sample i_sample;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    per_layer_range_tracker u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sample (i_sample),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    range_checker board = new();

    // Sixteen distinct keys that fill the table in the directed opener; the
    // random part keeps revisiting them.
    logic [31:0] key_pool [MAX_LAYERS] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0001, 32'h0001_0000, 32'h0001_0001, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_8000, 32'hFFFE_0000, 32'h1234_5678,
        32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h4000_0000
    };
    logic [31:0] last_key = 32'h0;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run; a clean run finishes in well under a tenth of this.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample the handshake and the result strobe at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Check before logging: a word accepted in the cycle a result is
            // shown belongs behind it in the queue either way.
            if (o_valid === 1'b1) board.check_result(o_result);
            if (start && busy === 1'b0) board.log_sample(i_sample);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_sample make_sample(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [31:0] d);
        t_sample s;
        s.pos_x   = x;
        s.pos_y   = y;
        s.pos_z   = z;
        s.density = d;
        return s;
    endfunction

    // Half full range, half a band straddling the +/-10000.0 box corners.
    function automatic logic [31:0] random_coord();
        if ($urandom_range(0, 1)) return $urandom;
        return $urandom_range(0, 1400000000) - 32'd700000000;
    endfunction

    function automatic t_sample random_sample();
        int          pick;
        logic [31:0] key;
        logic [31:0] den;
        pick = $urandom_range(0, 99);
        // Mostly known layers (repeats test back-to-back updates of one
        // entry), then fresh keys and one-bit near misses that overflow.
        if (pick < 20)
            key = last_key;
        else if (pick < 80)
            key = key_pool[$urandom_range(0, MAX_LAYERS - 1)];
        else if (pick < 90)
            key = $urandom;
        else
            key = key_pool[$urandom_range(0, MAX_LAYERS - 1)] ^ (32'h1 << $urandom_range(0, 31));
        last_key = key;
        den = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000) - 32'd1000;
        return make_sample(random_coord(), random_coord(), key, den);
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        start    = 1'b1;
        i_sample = s;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
    endtask

    // Drop start for a short random stretch; drive junk meanwhile.
    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start    = 1'b0;
            i_sample = make_sample($urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input int idle_pct);
        for (int k = 0; k < count; k++) begin
            sender_gap(idle_pct);
            send_sample(random_sample());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int guard;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_sample = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // First layer, then its density range pushed to both extremes.
        send_sample(make_sample(32'h0, 32'h0, key_pool[0], 32'h0));
        send_sample(make_sample(32'h0, 32'h0, key_pool[0], 32'h7FFF_FFFF));
        send_sample(make_sample(32'h0, 32'h0, key_pool[0], 32'h8000_0000));
        // Coordinates sitting exactly on the start corners min_x and max_y leave those alone.
        send_sample(make_sample(32'd655360000, -32'sd655360000, key_pool[1], 32'd5));
        // Coordinate extremes open the box all the way.
        send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, key_pool[2], 32'hFFFF_FFFF));
        send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, key_pool[3], 32'h1));
        // Fill the rest of the table.
        for (int k = 4; k < MAX_LAYERS; k++)
            send_sample(make_sample($urandom, $urandom, key_pool[k], $urandom));
        // New key with the table full, then a hit that still records.
        send_sample(make_sample(32'h1, 32'h1, 32'h0000_0002, 32'h0));
        send_sample(make_sample(32'h0, 32'h0, key_pool[0], 32'h0001_2345));
        // Key one bit off a stored key is a distinct layer, so it overflows.
        send_sample(make_sample(32'h0, 32'h0, 32'hFFFF_FFFE, 32'h0));
        drain();

        random_phase(135, 36);
        drain();
        random_phase(135, 77);
        drain();
        random_phase(135, 0);

        @(negedge i_clk);
        start = 1'b0;

        // Wait out the last results, with a bound, then a short tail.
        guard = 0;
        while (board.outstanding() != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (board.outstanding() != 0)
            board.report($sformatf("%0d results never arrived", board.outstanding()));

        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
